FILE: rtl/core/trqbd_pkg.sv
// ----------------------------------------------------------------------------
// trqbd_pkg
// Shared types, codes and defaults of the ticketed ring queue.
// ----------------------------------------------------------------------------
package trqbd_pkg;

  localparam int TICKET_W        = 32;
  localparam int QUEUE_DEPTH_DEF = 256;
  localparam int MAX_BATCH_DEF   = 8;

  localparam logic [TICKET_W-1:0] EMPTY_TICKET = '1;

  // result status codes
  localparam logic [1:0] ST_ENQ_OK       = 2'd0;
  localparam logic [1:0] ST_ENQ_BUSY     = 2'd1;
  localparam logic [1:0] ST_DEQ_ITEM     = 2'd2;
  localparam logic [1:0] ST_DEQ_NOTREADY = 2'd3;

  // operation codes
  localparam logic FN_ENQ = 1'b0;
  localparam logic FN_DEQ = 1'b1;

  typedef struct packed {
    logic               func;
    logic signed [31:0] value;
    logic        [3:0]  batch_count;
  } in_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic signed [31:0] item_data;
    logic               item_skipped;
    logic               last_item;
  } out_t;

  typedef struct packed {
    logic clr;
    logic accept;
    logic enq_fin;
    logic chk_rd;
    logic chk_eval;
    logic em_rd;
    logic em_out;
    logic fail_out;
  } cmd_t;

  typedef struct packed {
    logic in_enq;
    logic in_kzero;
    logic last;
    logic ready;
    logic clr_done;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/core/trqbd_ram.sv
// ----------------------------------------------------------------------------
// trqbd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module trqbd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/trqbd_ctrl.sv
// ----------------------------------------------------------------------------
// trqbd_ctrl
// Sequencer for clearing pass, enqueue, batch check and batch delivery.
// ----------------------------------------------------------------------------
module trqbd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output trqbd_pkg::cmd_t   cmd,
  input  trqbd_pkg::sts_t   sts
);
  import trqbd_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_ENQ    = 3'd2;
  localparam logic [2:0] S_CHK_RD = 3'd3;
  localparam logic [2:0] S_CHK_EV = 3'd4;
  localparam logic [2:0] S_EM_RD  = 3'd5;
  localparam logic [2:0] S_EM_OUT = 3'd6;
  localparam logic [2:0] S_FAIL   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.in_enq) begin
            state_next = S_ENQ;
          end else if (sts.in_kzero) begin
            state_next = S_FAIL;
          end else begin
            state_next = S_CHK_RD;
          end
        end
      end
      S_ENQ: begin
        if (sts.out_free) begin
          cmd.enq_fin = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_CHK_RD: begin
        cmd.chk_rd = 1'b1;
        state_next = S_CHK_EV;
      end
      S_CHK_EV: begin
        cmd.chk_eval = 1'b1;
        if (sts.last) begin
          state_next = S_FAIL;
        end else begin
          state_next = S_CHK_RD;
        end
      end
      S_EM_RD: begin
        cmd.em_rd  = 1'b1;
        state_next = S_EM_OUT;
      end
      S_EM_OUT: begin
        if (sts.out_free) begin
          cmd.em_out = 1'b1;
          state_next = sts.last ? S_IDLE : S_EM_RD;
        end
      end
      S_FAIL: begin
        if (sts.out_free) begin
          cmd.fail_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    // the last check step decides between delivery and refusal
    if (state == S_CHK_EV && sts.last && sts.ready) begin
      state_next = S_EM_RD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  a_accept_then_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> in_stall)
    else $error("accepted word not followed by stall");

  a_clear_no_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.clr |-> !cmd.accept)
    else $error("word accepted during clearing pass");

endmodule

FILE: rtl/core/trqbd_dp.sv
// ----------------------------------------------------------------------------
// trqbd_dp
// Ring storage, head and tail tickets, slot walk and output register.
// ----------------------------------------------------------------------------
module trqbd_dp #(
  parameter int QUEUE_DEPTH = trqbd_pkg::QUEUE_DEPTH_DEF,
  parameter int MAX_BATCH   = trqbd_pkg::MAX_BATCH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  trqbd_pkg::in_t    in_word,
  input  trqbd_pkg::cmd_t   cmd,
  output trqbd_pkg::sts_t   sts,
  output logic              out_valid,
  input  logic              out_stall,
  output trqbd_pkg::out_t   out_word
);
  import trqbd_pkg::*;

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int SLOT_W = $clog2(MAX_BATCH + 1);

  logic [TICKET_W-1:0]  head;
  logic [TICKET_W-1:0]  tail;
  logic [PTR_W-1:0]     head_pos;
  logic [PTR_W-1:0]     tail_pos;
  logic [TICKET_W-1:0]  base_t;
  logic [PTR_W-1:0]     base_pos;
  logic [TICKET_W-1:0]  cur_t;
  logic [PTR_W-1:0]     cur_pos;
  logic [SLOT_W-1:0]    slot;
  logic [SLOT_W-1:0]    last_slot;
  logic [MAX_BATCH-1:0] slot_mask;
  logic [MAX_BATCH-1:0] skip_vec;
  logic                 ready;
  logic [31:0]          enq_value;

  logic [TICKET_W-1:0]  ticket_rd;
  logic [TICKET_W-1:0]  gap_rd;
  logic [31:0]          word_rd;

  logic [SLOT_W-1:0]    k_sat;
  logic [PTR_W-1:0]     cur_pos_next;
  logic [PTR_W-1:0]     tail_pos_next;
  logic                 slot_last;
  logic                 cur_skip;
  logic                 match;
  logic                 gap_ok;
  logic                 cell_free;
  logic                 out_free;

  logic                 t_wr_en, g_wr_en, w_wr_en;
  logic [PTR_W-1:0]     wr_addr;
  logic [TICKET_W-1:0]  t_wr_data, g_wr_data;
  logic [31:0]          w_wr_data;
  logic                 t_rd_en;
  logic [PTR_W-1:0]     t_rd_addr;

  always_comb begin
    if (32'(in_word.batch_count) > 32'(MAX_BATCH)) begin
      k_sat = SLOT_W'(MAX_BATCH);
    end else begin
      k_sat = SLOT_W'(in_word.batch_count);
    end
  end

  // ring position follows the ticket, including the wrap of the ticket itself
  assign cur_pos_next  = (cur_t == EMPTY_TICKET) ? '0 :
                         (cur_pos == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : cur_pos + PTR_W'(1);
  assign tail_pos_next = (tail == EMPTY_TICKET) ? '0 :
                         (tail_pos == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_pos + PTR_W'(1);

  assign slot_last = (slot == last_slot);
  assign cur_skip  = |(skip_vec & slot_mask);
  assign match     = (ticket_rd == cur_t);
  assign gap_ok    = ($signed(gap_rd) >= $signed(cur_t));
  assign cell_free = ticket_rd[TICKET_W-1];
  assign out_free  = !out_valid || !out_stall;

  assign sts.in_enq   = (in_word.func == FN_ENQ);
  assign sts.in_kzero = (in_word.batch_count == '0);
  assign sts.last     = slot_last;
  assign sts.ready    = ready && (match || gap_ok);
  assign sts.clr_done = (cur_pos == PTR_W'(QUEUE_DEPTH - 1));
  assign sts.out_free = out_free;

  // memory port steering
  always_comb begin
    wr_addr   = cmd.enq_fin ? tail_pos : cur_pos;
    t_wr_en   = cmd.clr || (cmd.enq_fin && cell_free) || (cmd.em_out && !cur_skip);
    t_wr_data = cmd.enq_fin ? tail : EMPTY_TICKET;
    g_wr_en   = cmd.clr || (cmd.enq_fin && !cell_free);
    g_wr_data = cmd.clr ? EMPTY_TICKET : tail;
    w_wr_en   = cmd.clr || (cmd.enq_fin && cell_free);
    w_wr_data = cmd.clr ? '0 : enq_value;
    t_rd_en   = cmd.accept || cmd.chk_rd;
    t_rd_addr = cmd.accept ? tail_pos : cur_pos;
  end

  trqbd_ram #(.WIDTH(TICKET_W), .DEPTH(QUEUE_DEPTH)) u_ticket_ram (
    .clk     (clk),
    .wr_en   (t_wr_en),
    .wr_addr (wr_addr),
    .wr_data (t_wr_data),
    .rd_en   (t_rd_en),
    .rd_addr (t_rd_addr),
    .rd_data (ticket_rd)
  );

  trqbd_ram #(.WIDTH(TICKET_W), .DEPTH(QUEUE_DEPTH)) u_gap_ram (
    .clk     (clk),
    .wr_en   (g_wr_en),
    .wr_addr (wr_addr),
    .wr_data (g_wr_data),
    .rd_en   (cmd.chk_rd),
    .rd_addr (cur_pos),
    .rd_data (gap_rd)
  );

  trqbd_ram #(.WIDTH(32), .DEPTH(QUEUE_DEPTH)) u_word_ram (
    .clk     (clk),
    .wr_en   (w_wr_en),
    .wr_addr (wr_addr),
    .wr_data (w_wr_data),
    .rd_en   (cmd.em_rd),
    .rd_addr (cur_pos),
    .rd_data (word_rd)
  );

  // tickets and slot walk
  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      head_pos <= '0;
      tail_pos <= '0;
      cur_pos  <= '0;
      ready    <= 1'b1;
    end else begin
      if (cmd.clr) begin
        cur_pos <= sts.clr_done ? '0 : cur_pos + PTR_W'(1);
      end
      if (cmd.accept) begin
        enq_value <= in_word.value;
        last_slot <= k_sat - SLOT_W'(1);
        base_t    <= head;
        base_pos  <= head_pos;
        cur_t     <= head;
        cur_pos   <= head_pos;
        slot      <= '0;
        slot_mask <= MAX_BATCH'(1);
        skip_vec  <= '0;
        ready     <= 1'b1;
      end
      if (cmd.enq_fin && cell_free) begin
        tail     <= tail + TICKET_W'(1);
        tail_pos <= tail_pos_next;
      end
      if (cmd.chk_eval) begin
        ready    <= ready && (match || gap_ok);
        skip_vec <= skip_vec | (slot_mask & {MAX_BATCH{!match && gap_ok}});
        if (slot_last) begin
          head      <= cur_t + TICKET_W'(1);
          head_pos  <= cur_pos_next;
          cur_t     <= base_t;
          cur_pos   <= base_pos;
          slot      <= '0;
          slot_mask <= MAX_BATCH'(1);
        end else begin
          cur_t     <= cur_t + TICKET_W'(1);
          cur_pos   <= cur_pos_next;
          slot      <= slot + SLOT_W'(1);
          slot_mask <= slot_mask << 1;
        end
      end
      if (cmd.em_out) begin
        cur_t     <= cur_t + TICKET_W'(1);
        cur_pos   <= cur_pos_next;
        slot      <= slot + SLOT_W'(1);
        slot_mask <= slot_mask << 1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.enq_fin || cmd.em_out || cmd.fail_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.enq_fin) begin
      out_word.status       <= cell_free ? ST_ENQ_OK : ST_ENQ_BUSY;
      out_word.item_data    <= '0;
      out_word.item_skipped <= 1'b0;
      out_word.last_item    <= 1'b1;
    end else if (cmd.em_out) begin
      out_word.status       <= ST_DEQ_ITEM;
      out_word.item_data    <= cur_skip ? '0 : $signed(word_rd);
      out_word.item_skipped <= cur_skip;
      out_word.last_item    <= slot_last;
    end else if (cmd.fail_out) begin
      out_word.status       <= ST_DEQ_NOTREADY;
      out_word.item_data    <= '0;
      out_word.item_skipped <= 1'b0;
      out_word.last_item    <= 1'b1;
    end
  end

  a_one_load: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.enq_fin, cmd.em_out, cmd.fail_out}))
    else $error("more than one result load in a cycle");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.enq_fin || cmd.em_out || cmd.fail_out) |-> out_free)
    else $error("result loaded over a waiting word");

  a_deliver_only_ready: assert property (@(posedge clk) disable iff (rst)
    cmd.em_out |-> ready)
    else $error("batch delivered after a failed check");

endmodule

FILE: rtl/core/ticketed_ring_queue_batch_dequeue_top.sv
// ----------------------------------------------------------------------------
// ticketed_ring_queue_batch_dequeue_top
// Ring of ticketed cells with single-word enqueue and batch dequeue.
// ----------------------------------------------------------------------------
// One input channel (in_valid, in_stall, in_word) takes enqueue and dequeue
// requests; one output channel (out_valid, out_stall, out_word) returns the
// results. A word is taken when valid is high and stall is low.
// After reset the block sweeps all QUEUE_DEPTH cells, one per cycle, to the
// empty state; in_stall is high throughout the sweep.
// One request is worked at a time; the next is taken once the last result
// of the current one is in the output register.
// Enqueue: one ticket read, then the write and result.
// Dequeue of k cells: per cell, a read and a compare of ticket and gap;
// then, if the batch is ready, per cell a read of the data word and its
// delivery, else one refusal result. Each cell memory has a single read
// port, so cells are worked one at a time. A zero count is refused unchecked.
// A stalled receiver holds the output word; the block waits until it is taken.
// ----------------------------------------------------------------------------
module ticketed_ring_queue_batch_dequeue_top #(
  parameter int QUEUE_DEPTH = trqbd_pkg::QUEUE_DEPTH_DEF,
  parameter int MAX_BATCH   = trqbd_pkg::MAX_BATCH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  trqbd_pkg::in_t   in_word,
  output logic             out_valid,
  input  logic             out_stall,
  output trqbd_pkg::out_t  out_word
);
  import trqbd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  trqbd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  trqbd_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MAX_BATCH   (MAX_BATCH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_word   (in_word),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
